// File: rtl/br1rd_pkg.sv
// shared types and constants of the byterun1 row decoder
package br1rd_pkg;

  // field and state widths
  localparam int ROW_LEN_W     = 14;
  localparam int ROW_TOTAL_W   = 19;
  localparam int FILL_W        = 13;
  localparam int ROWS_W        = 20;
  localparam int RUN_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 19;
  localparam int OUT_LANES     = 8;
  localparam int LANE_CNT_W    = 4;
  localparam int OUT_W         = 64;

  localparam int MAX_ROW_LEN   = 8192;

  localparam logic [ROW_LEN_W-1:0]   ROW_LEN_RST   = ROW_LEN_W'(2);
  localparam logic [ROW_TOTAL_W-1:0] ROW_TOTAL_RST = ROW_TOTAL_W'(1);

  localparam logic [7:0] NOP_CODE = 8'h80;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOTAL = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_LIT,
    PH_REP
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_LIT_OVER,
    ERR_REP_OVER,
    ERR_LIT_TRUNC,
    ERR_REP_MISSING,
    ERR_ROW_INCOMPLETE,
    ERR_BAD_TRAILER
  } err_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } st_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic chunk_last;
  } sts_t;

endpackage

// File: rtl/br1rd_ctrl.sv
// controller state machine: input acceptance and result sequencing
module br1rd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  br1rd_pkg::sts_t   sts,
  output br1rd_pkg::cmd_t   cmd
);

  br1rd_pkg::st_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;
  logic           emit;
  logic           accept;

  assign out_free = !out_valid_r || !out_stall;

  // outputs
  always_comb begin
    emit     = (state_r == br1rd_pkg::ST_EMIT) && out_free;
    in_stall = !((state_r == br1rd_pkg::ST_IDLE) || (emit && sts.chunk_last));
    accept   = in_valid && !in_stall;
    cmd.load = accept;
    cmd.emit = emit;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      br1rd_pkg::ST_IDLE: begin
        if (accept) state_nxt = br1rd_pkg::ST_EMIT;
      end
      br1rd_pkg::ST_EMIT: begin
        if (emit && sts.chunk_last && !accept) state_nxt = br1rd_pkg::ST_IDLE;
      end
      default: state_nxt = br1rd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= br1rd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/br1rd_datapath.sv
// datapath: config registers, stream state, result descriptor, output register
module br1rd_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [br1rd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [br1rd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [7:0]                            in_byte,
  input  logic                                  in_is_last,
  input  br1rd_pkg::cmd_t                       cmd,
  output br1rd_pkg::sts_t                       sts,
  output logic [br1rd_pkg::OUT_W-1:0]           out_bytes,
  output logic [br1rd_pkg::LANE_CNT_W-1:0]      out_byte_count,
  output logic                                  out_run_end,
  output logic                                  out_row_end,
  output logic                                  out_stream_done,
  output logic [2:0]                            out_err_code
);

  // config
  logic [br1rd_pkg::ROW_LEN_W-1:0]   row_len_r;
  logic [br1rd_pkg::ROW_TOTAL_W-1:0] row_total_r;

  // stream state
  br1rd_pkg::phase_t                 phase_r, phase_nxt;
  logic [br1rd_pkg::RUN_W-1:0]       run_left_r, run_left_nxt;
  logic [br1rd_pkg::FILL_W-1:0]      row_fill_r, row_fill_nxt;
  logic [br1rd_pkg::ROWS_W-1:0]      rows_done_r, rows_done_nxt;
  br1rd_pkg::err_t                   err_r, err_nxt;

  // descriptor of the results still due for the current word
  logic [br1rd_pkg::RUN_W-1:0]       d_left_r, d_left_nxt;
  logic [7:0]                        d_byte_r;
  logic                              d_rend_r, d_rend_nxt;
  br1rd_pkg::err_t                   d_err_r, d_err_nxt;
  logic                              d_done_r, d_done_nxt;

  // output register
  logic [br1rd_pkg::OUT_W-1:0]       obytes_r, obytes_nxt;
  logic [br1rd_pkg::LANE_CNT_W-1:0]  ocount_r;
  logic                              orun_end_r, orow_end_r, odone_r;
  br1rd_pkg::err_t                   oerr_r;

  logic [br1rd_pkg::ROW_LEN_W-1:0]   eff_rb;
  logic [br1rd_pkg::ROW_TOTAL_W-1:0] eff_rt;
  logic [br1rd_pkg::ROW_LEN_W-1:0]   fill_ext;
  logic [br1rd_pkg::ROW_LEN_W-1:0]   room;
  logic [br1rd_pkg::ROW_LEN_W-1:0]   fill_t;
  logic [br1rd_pkg::RUN_W-1:0]       lit_cnt, rep_cnt;
  logic                              trailer;
  br1rd_pkg::err_t                   fin_err;
  logic [br1rd_pkg::LANE_CNT_W-1:0]  chunk;
  logic                              chunk_last;

  // effective register values and per-word state update
  always_comb begin
    eff_rb = row_len_r;
    if (row_len_r == '0) begin
      eff_rb = br1rd_pkg::ROW_LEN_W'(1);
    end else if (row_len_r > br1rd_pkg::ROW_LEN_W'(br1rd_pkg::MAX_ROW_LEN)) begin
      eff_rb = br1rd_pkg::ROW_LEN_W'(br1rd_pkg::MAX_ROW_LEN);
    end
    eff_rt   = (row_total_r == '0) ? br1rd_pkg::ROW_TOTAL_W'(1) : row_total_r;
    fill_ext = br1rd_pkg::ROW_LEN_W'(row_fill_r);
    room     = (fill_ext < eff_rb) ? (eff_rb - fill_ext) : '0;
    lit_cnt  = in_byte + 8'd1;
    rep_cnt  = ~in_byte + 8'd2;
    trailer  = rows_done_r >= br1rd_pkg::ROWS_W'(eff_rt);

    phase_nxt     = phase_r;
    run_left_nxt  = run_left_r;
    row_fill_nxt  = row_fill_r;
    rows_done_nxt = rows_done_r;
    err_nxt       = err_r;
    d_left_nxt    = '0;
    d_rend_nxt    = 1'b0;
    fill_t        = '0;

    if (err_r == br1rd_pkg::ERR_NONE) begin
      unique case (phase_r)
        br1rd_pkg::PH_CTRL: begin
          if (trailer) begin
            if (!((in_byte == br1rd_pkg::NOP_CODE) || ((in_byte == 8'd0) && in_is_last))) begin
              err_nxt = br1rd_pkg::ERR_BAD_TRAILER;
            end
          end else if (in_byte < br1rd_pkg::NOP_CODE) begin
            if (br1rd_pkg::ROW_LEN_W'(lit_cnt) > room) begin
              err_nxt = br1rd_pkg::ERR_LIT_OVER;
            end else if (in_is_last) begin
              err_nxt = br1rd_pkg::ERR_LIT_TRUNC;
            end else begin
              phase_nxt    = br1rd_pkg::PH_LIT;
              run_left_nxt = lit_cnt;
            end
          end else if (in_byte != br1rd_pkg::NOP_CODE) begin
            if (in_is_last) begin
              err_nxt = br1rd_pkg::ERR_REP_MISSING;
            end else if (br1rd_pkg::ROW_LEN_W'(rep_cnt) > room) begin
              err_nxt = br1rd_pkg::ERR_REP_OVER;
            end else begin
              phase_nxt    = br1rd_pkg::PH_REP;
              run_left_nxt = rep_cnt;
            end
          end
        end
        br1rd_pkg::PH_LIT: begin
          run_left_nxt = run_left_r - 8'd1;
          fill_t       = fill_ext + br1rd_pkg::ROW_LEN_W'(1);
          d_left_nxt   = 8'd1;
          if (fill_t >= eff_rb) begin
            row_fill_nxt  = '0;
            rows_done_nxt = rows_done_r + br1rd_pkg::ROWS_W'(1);
            d_rend_nxt    = 1'b1;
          end else begin
            row_fill_nxt = fill_t[br1rd_pkg::FILL_W-1:0];
          end
          if (run_left_nxt == '0) begin
            phase_nxt = br1rd_pkg::PH_CTRL;
          end else if (in_is_last) begin
            err_nxt = br1rd_pkg::ERR_LIT_TRUNC;
          end
        end
        default: begin
          // repeat value: the whole run lands at once
          fill_t       = fill_ext + br1rd_pkg::ROW_LEN_W'(run_left_r);
          d_left_nxt   = run_left_r;
          run_left_nxt = '0;
          phase_nxt    = br1rd_pkg::PH_CTRL;
          if (fill_t >= eff_rb) begin
            row_fill_nxt  = '0;
            rows_done_nxt = rows_done_r + br1rd_pkg::ROWS_W'(1);
            d_rend_nxt    = 1'b1;
          end else begin
            row_fill_nxt = fill_t[br1rd_pkg::FILL_W-1:0];
          end
        end
      endcase
    end

    // end of stream checks
    fin_err = err_nxt;
    if (fin_err == br1rd_pkg::ERR_NONE) begin
      if (phase_nxt == br1rd_pkg::PH_LIT) begin
        fin_err = br1rd_pkg::ERR_LIT_TRUNC;
      end else if (phase_nxt == br1rd_pkg::PH_REP) begin
        fin_err = br1rd_pkg::ERR_REP_MISSING;
      end else if (rows_done_nxt < br1rd_pkg::ROWS_W'(eff_rt)) begin
        fin_err = br1rd_pkg::ERR_ROW_INCOMPLETE;
      end
    end
    d_err_nxt  = in_is_last ? fin_err : err_nxt;
    d_done_nxt = in_is_last && (fin_err == br1rd_pkg::ERR_NONE);
    if (in_is_last) begin
      phase_nxt     = br1rd_pkg::PH_CTRL;
      run_left_nxt  = '0;
      row_fill_nxt  = '0;
      rows_done_nxt = '0;
      err_nxt       = br1rd_pkg::ERR_NONE;
    end
  end

  // chunk of up to eight lanes from the descriptor
  always_comb begin
    chunk_last = d_left_r <= br1rd_pkg::RUN_W'(br1rd_pkg::OUT_LANES);
    chunk      = (d_left_r < br1rd_pkg::RUN_W'(br1rd_pkg::OUT_LANES)) ?
                 d_left_r[br1rd_pkg::LANE_CNT_W-1:0] :
                 br1rd_pkg::LANE_CNT_W'(br1rd_pkg::OUT_LANES);
    obytes_nxt = '0;
    for (int i = 0; i < br1rd_pkg::OUT_LANES; i++) begin
      if (br1rd_pkg::LANE_CNT_W'(i) < chunk) obytes_nxt[8*i +: 8] = d_byte_r;
    end
  end

  assign sts.chunk_last = chunk_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r   <= br1rd_pkg::ROW_LEN_RST;
      row_total_r <= br1rd_pkg::ROW_TOTAL_RST;
      phase_r     <= br1rd_pkg::PH_CTRL;
      run_left_r  <= '0;
      row_fill_r  <= '0;
      rows_done_r <= '0;
      err_r       <= br1rd_pkg::ERR_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          br1rd_pkg::CFG_ROW_LEN:   row_len_r   <= cfg_data[br1rd_pkg::ROW_LEN_W-1:0];
          br1rd_pkg::CFG_ROW_TOTAL: row_total_r <= cfg_data[br1rd_pkg::ROW_TOTAL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        phase_r     <= phase_nxt;
        run_left_r  <= run_left_nxt;
        row_fill_r  <= row_fill_nxt;
        rows_done_r <= rows_done_nxt;
        err_r       <= err_nxt;
      end
    end
  end

  // descriptor and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_left_r <= d_left_nxt;
      d_byte_r <= in_byte;
      d_rend_r <= d_rend_nxt;
      d_err_r  <= d_err_nxt;
      d_done_r <= d_done_nxt;
    end else if (cmd.emit) begin
      d_left_r <= d_left_r - br1rd_pkg::RUN_W'(chunk);
    end
    if (cmd.emit) begin
      obytes_r   <= obytes_nxt;
      ocount_r   <= chunk;
      orun_end_r <= chunk_last;
      orow_end_r <= chunk_last && d_rend_r;
      odone_r    <= chunk_last && d_done_r;
      oerr_r     <= d_err_r;
    end
  end

  assign out_bytes       = obytes_r;
  assign out_byte_count  = ocount_r;
  assign out_run_end     = orun_end_r;
  assign out_row_end     = orow_end_r;
  assign out_stream_done = odone_r;
  assign out_err_code    = oerr_r;

endmodule

// File: rtl/byterun1_row_decoder.sv
// top level of the byterun1 (packbits) row decoder
// Decodes a packbits-compressed body, one byte word per accepted input, into rows of
// row_len bytes, row_total rows per stream; the word flagged in_is_last ends the
// stream and the block then starts fresh for the next one (config is kept). Every input
// word gives at least one result word: a literal byte gives one result with one byte,
// a control byte, no-op or ignored byte gives one empty result, and a repeat of n bytes
// gives ceil(n/8) results of up to eight lanes each (up to 16 for a run of 128). The
// input word is registered into a descriptor, and the results then leave one per cycle
// whenever the single eight-lane output register is free. The next word is taken in
// the same cycle as the previous word's last result is loaded, so single-result words
// flow at one per cycle while the output register stays free.
// Errors stick until the last word of the stream and are reported on every result.
// Config writes are always ready; write them only while the block is idle.
module byterun1_row_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // config write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [br1rd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [br1rd_pkg::CFG_DATA_W-1:0]      cfg_data,
  // compressed byte input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_byte,
  input  logic                                  in_is_last,
  // decoded result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [br1rd_pkg::OUT_W-1:0]           out_bytes,
  output logic [br1rd_pkg::LANE_CNT_W-1:0]      out_byte_count,
  output logic                                  out_run_end,
  output logic                                  out_row_end,
  output logic                                  out_stream_done,
  output logic [2:0]                            out_err_code
);

  br1rd_pkg::cmd_t cmd;
  br1rd_pkg::sts_t sts;

  // config port never back-pressures
  assign cfg_ready = 1'b1;

  // sequencing: accept, then one result per free output slot
  br1rd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // decode state, run descriptor and output register
  br1rd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_byte         (in_byte),
    .in_is_last      (in_is_last),
    .cmd             (cmd),
    .sts             (sts),
    .out_bytes       (out_bytes),
    .out_byte_count  (out_byte_count),
    .out_run_end     (out_run_end),
    .out_row_end     (out_row_end),
    .out_stream_done (out_stream_done),
    .out_err_code    (out_err_code)
  );

  // a clean end of stream is only flagged on the closing result, with no error
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stream_done) |->
      (out_run_end && (out_err_code == 3'(br1rd_pkg::ERR_NONE))))
    else $error("stream_done without clean closing result");

  // a row only completes on the last result of a word
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_end) |-> out_run_end)
    else $error("row_end on a non-final result");

  // results before the last one of a repeat carry all lanes
  a_full_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_end) |->
      (out_byte_count == br1rd_pkg::LANE_CNT_W'(br1rd_pkg::OUT_LANES)))
    else $error("partial lane count before end of run");

  // a new word is only taken once the previous word's results are all issued
  a_load_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && cmd.emit) |-> sts.chunk_last)
    else $error("input taken while results still pending");

endmodule

// File: tb/sv/byterun1_row_decoder_tb.sv
// self-checking testbench for the byterun1 row decoder with its own decode predictor
module byterun1_row_decoder_tb;
  import br1rd_pkg::*;

  // no register sits behind this index, a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG  = CFG_IDX_W'(3);
  // longest run of cycles in which no channel moves a word
  localparam int                   QUIET_LIMIT = 1000;
  localparam int                   SQUEEZE_LEN = 120;
  localparam int                   SETTLE      = 4;
  // decoded bytes after which a random body stops growing
  localparam int                   BODY_CAP    = 120;
  // row filled by longest repeats only
  localparam int                   HEAVY_ROW   = 2048;

  // one decoded result word
  typedef struct {
    logic [OUT_W-1:0]      lanes;
    logic [LANE_CNT_W-1:0] count;
    logic                  run_end;
    logic                  row_end;
    logic                  done;
    err_t                  err;
  } decoded_t;

  // predicts the result words of every accepted byte and checks the block against them
  class row_decode_sb;
    logic [ROW_LEN_W-1:0]   row_len;
    logic [ROW_TOTAL_W-1:0] row_total;
    phase_t                 phase;
    logic [RUN_W-1:0]       run_left;
    int unsigned            row_fill;
    logic [ROWS_W-1:0]      rows_done;
    err_t                   err_held;
    decoded_t               pending_results[$];
    int                     mismatches;
    int                     results_seen;

    function new();
      row_len      = ROW_LEN_RST;
      row_total    = ROW_TOTAL_RST;
      mismatches   = 0;
      results_seen = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      phase     = PH_CTRL;
      run_left  = '0;
      row_fill  = 0;
      rows_done = '0;
      err_held  = ERR_NONE;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_ROW_LEN) begin
        row_len = value[ROW_LEN_W-1:0];
      end else if (idx == CFG_ROW_TOTAL) begin
        row_total = value[ROW_TOTAL_W-1:0];
      end
    endfunction

    function int unsigned eff_row_len();
      int unsigned rb;
      rb = row_len;
      if (rb == 0) rb = 1;
      if (rb > MAX_ROW_LEN) rb = MAX_ROW_LEN;
      return rb;
    endfunction

    function int unsigned eff_row_total();
      return (row_total == 0) ? 1 : row_total;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function logic close_row();
      if (row_fill >= eff_row_len()) begin
        row_fill  = 0;
        rows_done = rows_done + 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function decoded_t make_result(logic [OUT_W-1:0] lanes, int unsigned count, logic rend);
      decoded_t r;
      r.lanes   = lanes;
      r.count   = LANE_CNT_W'(count);
      r.run_end = 1'b0;
      r.row_end = rend;
      r.done    = 1'b0;
      r.err     = ERR_NONE;
      return r;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      decoded_t         got[$];
      int unsigned      rb, room, cnt, left, lanes_now;
      logic [OUT_W-1:0] word;
      logic             rend;
      err_t             fin;
      rb   = eff_row_len();
      room = (row_fill < rb) ? rb - row_fill : 0;
      if (err_held == ERR_NONE) begin
        case (phase)
          PH_CTRL: begin
            if (rows_done >= eff_row_total()) begin
              // trailer: no-ops, and a zero only as the closing byte
              if (!(b == NOP_CODE || (b == 8'h00 && last))) err_held = ERR_BAD_TRAILER;
            end else if (b < NOP_CODE) begin
              cnt = b + 1;
              if (cnt > room) begin
                err_held = ERR_LIT_OVER;
              end else if (last) begin
                err_held = ERR_LIT_TRUNC;
              end else begin
                phase    = PH_LIT;
                run_left = RUN_W'(cnt);
              end
            end else if (b != NOP_CODE) begin
              cnt = 257 - b;
              if (last) begin
                err_held = ERR_REP_MISSING;
              end else if (cnt > room) begin
                err_held = ERR_REP_OVER;
              end else begin
                phase    = PH_REP;
                run_left = RUN_W'(cnt);
              end
            end
          end
          PH_LIT: begin
            run_left = run_left - 1'b1;
            row_fill = row_fill + 1;
            rend     = close_row();
            got.push_back(make_result(OUT_W'(b), 1, rend));
            if (run_left == 0) begin
              phase = PH_CTRL;
            end else if (last) begin
              err_held = ERR_LIT_TRUNC;
            end
          end
          default: begin
            left     = run_left;
            row_fill = row_fill + run_left;
            run_left = '0;
            phase    = PH_CTRL;
            rend     = close_row();
            while (left > 0) begin
              lanes_now = (left < OUT_LANES) ? left : OUT_LANES;
              word      = '0;
              for (int i = 0; i < lanes_now; i++) word[8*i +: 8] = b;
              left = left - lanes_now;
              got.push_back(make_result(word, lanes_now, (left == 0) ? rend : 1'b0));
            end
          end
        endcase
      end
      if (got.size() == 0) got.push_back(make_result('0, 0, 1'b0));
      fin = err_held;
      if (last && fin == ERR_NONE) begin
        if (phase == PH_LIT) begin
          fin = ERR_LIT_TRUNC;
        end else if (phase == PH_REP) begin
          fin = ERR_REP_MISSING;
        end else if (rows_done < eff_row_total()) begin
          fin = ERR_ROW_INCOMPLETE;
        end
      end
      foreach (got[k]) got[k].err = fin;
      got[got.size()-1].run_end = 1'b1;
      if (last) begin
        got[got.size()-1].done = (fin == ERR_NONE);
        clear_stream();
      end
      foreach (got[k]) pending_results.push_back(got[k]);
    endfunction

    function void match_result(logic [OUT_W-1:0] lanes, logic [LANE_CNT_W-1:0] count,
                               logic run_end, logic row_end, logic done, logic [2:0] err);
      decoded_t w;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with none due: out_bytes %h byte_count %0d", lanes, count);
        mismatches++;
      end else begin
        w = pending_results.pop_front();
        if (lanes !== w.lanes) begin
          $error("out_bytes: expected %h, got %h", w.lanes, lanes);
          mismatches++;
        end
        if (count !== w.count) begin
          $error("byte_count: expected %0d, got %0d", w.count, count);
          mismatches++;
        end
        if (run_end !== w.run_end) begin
          $error("run_end: expected %0b, got %0b", w.run_end, run_end);
          mismatches++;
        end
        if (row_end !== w.row_end) begin
          $error("row_end: expected %0b, got %0b", w.row_end, row_end);
          mismatches++;
        end
        if (done !== w.done) begin
          $error("stream_done: expected %0b, got %0b", w.done, done);
          mismatches++;
        end
        if (err !== w.err) begin
          $error("err_code: expected %0d, got %0d", w.err, err);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_byte;
  logic                  in_is_last;
  logic                  out_valid;
  logic                  out_stall;
  logic [OUT_W-1:0]      out_bytes;
  logic [LANE_CNT_W-1:0] out_byte_count;
  logic                  out_run_end;
  logic                  out_row_end;
  logic                  out_stream_done;
  logic [2:0]            out_err_code;

  row_decode_sb sb;

  // no_idle and hold_request are shared between the sender and the receiver; the rest count the run
  bit no_idle       = 1'b0;  // both sides run without gaps
  int hold_request  = 0;     // receiver holds off this many cycles at its next word
  int words_sent    = 0;
  int streams_sent  = 0;
  int clean_streams = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  byterun1_row_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bytes       (out_bytes),
    .out_byte_count  (out_byte_count),
    .out_run_end     (out_run_end),
    .out_row_end     (out_row_end),
    .out_stream_done (out_stream_done),
    .out_err_code    (out_err_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // control byte for a literal of n bytes, 1..128
  function automatic logic [7:0] lit_op(input int n);
    return 8'(n - 1);
  endfunction

  // control byte for a repeat of n bytes, 2..128
  function automatic logic [7:0] rep_op(input int n);
    return 8'(257 - n);
  endfunction

  // offer one byte word after a random gap, return at the edge that takes it
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(b, last);
    words_sent++;
    if (last) streams_sent++;
  endtask

  // the final byte of the queue carries the last flag
  task automatic send_stream(input logic [7:0] s[$]);
    foreach (s[i]) send_word(s[i], i == s.size() - 1);
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random runs fill rows exactly (three rows if rt > 8, cut at BODY_CAP), optional trailer
  function automatic void make_stream(input int unsigned rb, input int unsigned rt,
                                      ref logic [7:0] s[$]);
    int unsigned fill, room, cnt, made, rows;
    s.delete();
    made = 0;
    rows = (rt <= 8) ? rt : 3;
    for (int r = 0; r < rows && made < BODY_CAP; r++) begin
      fill = 0;
      while (fill < rb && made < BODY_CAP) begin
        room = rb - fill;
        if ($urandom_range(0, 9) == 0) s.push_back(NOP_CODE);
        cnt = (room < 128) ? room : 128;
        case ($urandom_range(0, 3))
          0: ;
          1: cnt = $urandom_range(1, cnt);
          default: cnt = $urandom_range(1, (cnt < 8) ? cnt : 8);
        endcase
        if (cnt >= 2 && $urandom_range(0, 1) == 1) begin
          s.push_back(rep_op(cnt));
          s.push_back(8'($urandom_range(0, 255)));
        end else begin
          s.push_back(lit_op(cnt));
          repeat (cnt) s.push_back(8'($urandom_range(0, 255)));
        end
        fill += cnt;
        made += cnt;
      end
    end
    if (rows == rt && made < BODY_CAP) begin
      repeat ($urandom_range(0, 2)) s.push_back(NOP_CODE);
      if ($urandom_range(0, 1) == 1) s.push_back(8'h00);
    end
    if (s.size() == 0) s.push_back(NOP_CODE);
  endfunction

  // one register setting, then random streams until the word budget is spent
  task automatic run_phase(input logic [CFG_DATA_W-1:0] rb_val,
                           input logic [CFG_DATA_W-1:0] rt_val,
                           input int budget, input bit squeeze);
    logic [7:0] s[$];
    int         start, n_streams, cut;
    wait_drained();
    program_reg(CFG_ROW_LEN, rb_val);
    program_reg(CFG_ROW_TOTAL, rt_val);
    settings_used++;
    start     = words_sent;
    n_streams = 0;
    if (squeeze) hold_request = SQUEEZE_LEN;
    while (words_sent - start < budget) begin
      no_idle = (squeeze && n_streams < 2) || ($urandom_range(0, 4) == 0);
      make_stream(sb.eff_row_len(), sb.eff_row_total(), s);
      case ($urandom_range(0, 9))
        7: begin
          // cut the body short
          cut = $urandom_range(1, s.size());
          while (s.size() > cut) void'(s.pop_back());
        end
        8: s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
        9: begin
          s.delete();
          repeat ($urandom_range(1, 10)) s.push_back(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      send_stream(s);
      n_streams++;
    end
    no_idle = 1'b0;
  endtask

  // receiver: random stall per word, plus one long hold-off on request
  initial begin
    int gap, hold_len;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        hold_len     = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.match_result(out_bytes, out_byte_count, out_run_end, out_row_end,
                      out_stream_done, out_err_code);
      if (out_stream_done) clean_streams++;
    end
  end

  // watchdog: ends the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall) ||
                   (cfg_valid && cfg_ready))) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d cycles without a word moving", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] dq[$];
    logic [7:0] heavy[$];
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_ROW_LEN;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_byte    <= '0;
    in_is_last <= 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset settings: rows of two bytes, one row per stream
    settings_used++;
    // literal with extreme bytes, no-op and closing zero in the trailer
    dq = '{lit_op(2), 8'hFF, 8'h00, NOP_CODE, 8'h00};
    send_stream(dq);
    // repeat that fills the row, last flag on the value byte
    dq = '{rep_op(2), 8'hA5};
    send_stream(dq);
    // longest repeat as the final byte: missing value wins over overflow
    dq = '{rep_op(128)};
    send_stream(dq);
    // literal control as the final byte
    dq = '{lit_op(1)};
    send_stream(dq);
    // literal too long for the row, later bytes ignored while the error sticks
    dq = '{lit_op(6), 8'h12, NOP_CODE};
    send_stream(dq);
    // repeat too long for the row
    dq = '{rep_op(4), 8'h7F};
    send_stream(dq);
    // stream ends inside a literal
    dq = '{lit_op(2), 8'h11};
    send_stream(dq);
    // stream ends with the row missing
    dq = '{NOP_CODE};
    send_stream(dq);
    // bad trailer after the last row
    dq = '{lit_op(2), 8'h11, 8'h22, lit_op(128), NOP_CODE};
    send_stream(dq);
    // row shrinks mid stream below the fill, so any run overflows
    send_word(lit_op(1), 1'b0);
    send_word(8'h55, 1'b0);
    wait_drained();
    program_reg(CFG_ROW_LEN, CFG_DATA_W'(1));
    send_word(lit_op(1), 1'b0);
    send_word(NOP_CODE, 1'b1);

    // a write to an index with no register behind it
    wait_drained();
    program_reg(CFG_NO_REG, '1);

    // random part over a spread of settings, extremes included
    run_phase(CFG_DATA_W'(3),      CFG_DATA_W'(2),      32, 1'b0);
    run_phase(CFG_DATA_W'(0),      CFG_DATA_W'(0),      24, 1'b0);  // zeros act as one
    run_phase(CFG_DATA_W'(1),      CFG_DATA_W'(6),      32, 1'b1);  // long hold-off here
    run_phase(CFG_DATA_W'(10),     CFG_DATA_W'(3),      32, 1'b0);
    run_phase(CFG_DATA_W'(37),     CFG_DATA_W'(2),      40, 1'b0);
    run_phase(CFG_DATA_W'(100),    CFG_DATA_W'(1),      60, 1'b0);
    run_phase('1,                  CFG_DATA_W'(524287), 24, 1'b0);  // row clamps to max
    run_phase(CFG_DATA_W'(5),      CFG_DATA_W'(524280), 24, 1'b0);

    // long row filled by longest repeats only: sixteen result words each
    wait_drained();
    program_reg(CFG_ROW_LEN, CFG_DATA_W'(HEAVY_ROW));
    program_reg(CFG_ROW_TOTAL, CFG_DATA_W'(1));
    settings_used++;
    heavy.delete();
    repeat (HEAVY_ROW / 128) begin
      heavy.push_back(rep_op(128));
      heavy.push_back(8'($urandom_range(0, 255)));
    end
    send_stream(heavy);

    run_phase(CFG_DATA_W'(4),      CFG_DATA_W'(4),      32, 1'b0);

    // all words in: let the last results drain, then a short tail
    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d byte words in %0d streams under %0d register settings",
             words_sent, streams_sent, settings_used);
    $display("%0d result words compared, %0d streams ended clean, %0d mismatches",
             sb.results_seen, clean_streams, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/br1rd_pkg.sv
rtl/br1rd_ctrl.sv
rtl/br1rd_datapath.sv
rtl/byterun1_row_decoder.sv
tb/sv/byterun1_row_decoder_tb.sv
